>>> rtl/core/srot_pkg.sv
// Shared widths and stage bundle types for the segment/rectangle overlap pipeline.
package srot_pkg;

	localparam int CoordW = 16;            // input coordinate width
	localparam int DiffW  = CoordW + 1;    // coordinate difference width
	localparam int ProdW  = 2 * DiffW;     // product of two differences
	localparam int NumW   = ProdW + 2;     // sum of two products, with margin

	// Stage 1 -> stage 2: operands for the multipliers
	typedef struct packed {
		logic                     pass;    // x-extents overlap and rectangle is not inverted
		logic signed [CoordW-1:0] ys;
		logic signed [CoordW-1:0] top;
		logic signed [CoordW-1:0] bottom;
		logic signed [DiffW-1:0]  dy;
		logic signed [DiffW-1:0]  d;       // |dx|, or 1 for a vertical segment
		logic signed [DiffW-1:0]  off_a;   // signed x offset at the low clip point
		logic signed [DiffW-1:0]  off_b;   // signed x offset at the high clip point
	} srot_prep_t;

	// Stage 2 -> stage 3: registered products
	typedef struct packed {
		logic                    pass;
		logic signed [ProdW-1:0] ysd;      // ys * d
		logic signed [ProdW-1:0] pa;       // dy * off_a
		logic signed [ProdW-1:0] pb;       // dy * off_b
		logic signed [ProdW-1:0] td;       // top * d
		logic signed [ProdW-1:0] bd;       // bottom * d
	} srot_prod_t;

endpackage

>>> rtl/core/srot_prep.sv
// Stage 1: clips the segment's x-extent to the rectangle and forms multiplier operands.
module srot_prep import srot_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic signed [CoordW-1:0] rect_left,
	input  logic signed [CoordW-1:0] rect_top,
	input  logic signed [CoordW-1:0] rect_right,
	input  logic signed [CoordW-1:0] rect_bottom,
	input  logic signed [CoordW-1:0] seg_x_start,
	input  logic signed [CoordW-1:0] seg_y_start,
	input  logic signed [CoordW-1:0] seg_x_end,
	input  logic signed [CoordW-1:0] seg_y_end,
	output logic                     vld_s1,
	output srot_prep_t               prep_s1
);

	logic signed [CoordW-1:0] x_min, x_max, lo, hi;
	logic signed [DiffW-1:0]  dx, off_lo, off_hi;
	logic                     vertical, rising;
	srot_prep_t               prep_d;

	// Clip x-extent: lo = max(min(xs,xe), left), hi = min(max(xs,xe), right)
	always_comb begin
		x_min    = (seg_x_start < seg_x_end) ? seg_x_start : seg_x_end;
		x_max    = (seg_x_start < seg_x_end) ? seg_x_end : seg_x_start;
		lo       = (x_min > rect_left) ? x_min : rect_left;
		hi       = (x_max < rect_right) ? x_max : rect_right;
		dx       = DiffW'(seg_x_end) - DiffW'(seg_x_start);
		off_lo   = DiffW'(lo) - DiffW'(seg_x_start);
		off_hi   = DiffW'(hi) - DiffW'(seg_x_start);
		vertical = (seg_x_start == seg_x_end);
		rising   = (seg_x_end > seg_x_start);
	end

	// Fold the sign of dx into the offsets so the denominator stays positive
	always_comb begin
		prep_d.pass   = (lo <= hi) && (rect_top <= rect_bottom);
		prep_d.ys     = seg_y_start;
		prep_d.top    = rect_top;
		prep_d.bottom = rect_bottom;
		prep_d.dy     = DiffW'(seg_y_end) - DiffW'(seg_y_start);
		if (vertical) begin
			// y values are the endpoints: ys + dy*0 and ys + dy*1
			prep_d.d     = DiffW'(1);
			prep_d.off_a = '0;
			prep_d.off_b = DiffW'(1);
		end else if (rising) begin
			prep_d.d     = dx;
			prep_d.off_a = off_lo;
			prep_d.off_b = off_hi;
		end else begin
			prep_d.d     = -dx;
			prep_d.off_a = -off_lo;
			prep_d.off_b = -off_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		prep_s1 <= prep_d;
	end

endmodule

>>> rtl/core/srot_mul.sv
// Stage 2: five parallel signed multiplies of up to 17x17 bits, registered.
module srot_mul import srot_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld_s1,
	input  srot_prep_t prep_s1,
	output logic       vld_s2,
	output srot_prod_t prod_s2
);

	logic signed [ProdW-1:0] ys_x, top_x, bot_x, dy_x, d_x, oa_x, ob_x;
	srot_prod_t              prod_d;

	// Sign-extend operands to product width; every product fits exactly
	always_comb begin
		ys_x  = ProdW'(prep_s1.ys);
		top_x = ProdW'(prep_s1.top);
		bot_x = ProdW'(prep_s1.bottom);
		dy_x  = ProdW'(prep_s1.dy);
		d_x   = ProdW'(prep_s1.d);
		oa_x  = ProdW'(prep_s1.off_a);
		ob_x  = ProdW'(prep_s1.off_b);

		prod_d.pass = prep_s1.pass;
		prod_d.ysd  = ys_x * d_x;
		prod_d.pa   = dy_x * oa_x;
		prod_d.pb   = dy_x * ob_x;
		prod_d.td   = top_x * d_x;
		prod_d.bd   = bot_x * d_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_d;
	end

endmodule

>>> rtl/core/srot_cmp.sv
// Stages 3 and 4: rational y values at both clip points and the bound comparisons.
module srot_cmp import srot_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld_s2,
	input  srot_prod_t prod_s2,
	output logic       done,
	output logic       hit
);

	logic                   vld_s3;
	logic                   pass_s3;
	logic signed [NumW-1:0] na_s3, nb_s3, td_s3, bd_s3;
	logic                   a_le_b, a_le_bd, b_le_bd, td_le_a, td_le_b;
	logic                   lo_ok, hi_ok;
	logic                   done_s4, hit_s4;

	// Stage 3: numerators N = ys*d + dy*off at both clip points
	always_ff @(posedge clk) begin
		pass_s3 <= prod_s2.pass;
		na_s3   <= NumW'(prod_s2.ysd) + NumW'(prod_s2.pa);
		nb_s3   <= NumW'(prod_s2.ysd) + NumW'(prod_s2.pb);
		td_s3   <= NumW'(prod_s2.td);
		bd_s3   <= NumW'(prod_s2.bd);
	end

	// Stage 4: min/max of the two y values against top*d and bottom*d
	always_comb begin
		a_le_b  = (na_s3 <= nb_s3);
		a_le_bd = (na_s3 <= bd_s3);
		b_le_bd = (nb_s3 <= bd_s3);
		td_le_a = (td_s3 <= na_s3);
		td_le_b = (td_s3 <= nb_s3);
		lo_ok   = a_le_b ? a_le_bd : b_le_bd;
		hi_ok   = a_le_b ? td_le_b : td_le_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			vld_s3  <= vld_s2;
			done_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4 <= pass_s3 && lo_ok && hi_ok;
	end

	assign done = done_s4;
	assign hit  = hit_s4;

endmodule

>>> rtl/core/segment_rect_overlap_test.sv
// Each accepted start passes through four registered stages: clip, multiply, sum, compare.
// Throughput: one item per cycle; the four-stage pipeline never stalls, busy stays low.
// Each result is shown for one cycle with done high; the receiver cannot hold it off.
// Reset (arst_n low) clears all stage valid bits at once; items in flight are dropped.
module segment_rect_overlap_test import srot_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [CoordW-1:0] rect_left,
	input  logic signed [CoordW-1:0] rect_top,
	input  logic signed [CoordW-1:0] rect_right,
	input  logic signed [CoordW-1:0] rect_bottom,
	input  logic signed [CoordW-1:0] seg_x_start,
	input  logic signed [CoordW-1:0] seg_y_start,
	input  logic signed [CoordW-1:0] seg_x_end,
	input  logic signed [CoordW-1:0] seg_y_end,
	output logic                     done,
	output logic                     hit
);

	logic       vld_s1, vld_s2;
	srot_prep_t prep_s1;
	srot_prod_t prod_s2;

	// Pipeline never backs up
	assign busy = 1'b0;

	srot_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (start),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_right  (rect_right),
		.rect_bottom (rect_bottom),
		.seg_x_start (seg_x_start),
		.seg_y_start (seg_y_start),
		.seg_x_end   (seg_x_end),
		.seg_y_end   (seg_y_end),
		.vld_s1      (vld_s1),
		.prep_s1     (prep_s1)
	);

	srot_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.prep_s1 (prep_s1),
		.vld_s2  (vld_s2),
		.prod_s2 (prod_s2)
	);

	srot_cmp u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s2  (vld_s2),
		.prod_s2 (prod_s2),
		.done    (done),
		.hit     (hit)
	);

	// Every accepted item yields exactly one result, through the clip, multiply, sum and compare registers
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("accepted item produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without an accepted item");

	// A hit requires a non-inverted rectangle
	a_hit_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> ($past(rect_left, 4) <= $past(rect_right, 4)
			&& $past(rect_top, 4) <= $past(rect_bottom, 4)))
		else $error("hit reported for inverted rectangle");

endmodule
